// ----- rtl/core/dqs_pkg.sv -----
// shared types, constants and helpers for the bounded deque with search
package dqs_pkg;

    // queue geometry
    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;

    // fixed field widths of the request and response
    localparam int DATA_W  = 32;
    localparam int KIND_W  = 3;
    localparam int POS_W   = 6;
    localparam int STAT_W  = 3;
    localparam int ENTRY_W = 7;
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    // request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_SEARCH     = 3'd4,
        KIND_DELETE     = 3'd5,
        KIND_CLEAR      = 3'd6
    } kind_t;

    // response status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_EMPTY     = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_BAD_POS   = 3'd4
    } status_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_WAIT,
        S_SEARCH,
        S_DELETE,
        S_RESULT
    } state_t;

    // entry memory access from the controller
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

    // ring slot of the entry at offset off from base
    function automatic logic [IDX_W-1:0] slot_add(logic [IDX_W-1:0] base,
                                                  logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ----- rtl/core/dqs_if.sv -----
// request and response channel interfaces of the deque
interface dqs_req_if;
    import dqs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;

    modport source (output valid, output kind, output value, output position, input ready);
    modport sink (input valid, input kind, input value, input position, output ready);
endinterface

interface dqs_rsp_if;
    import dqs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result_value;
    logic [POS_W-1:0]         found_position;
    logic [STAT_W-1:0]        status;
    logic [ENTRY_W-1:0]       entry_count;
    logic                     is_empty;

    modport source (output valid, output result_value, output found_position,
                    output status, output entry_count, output is_empty, input ready);
    modport sink (input valid, input result_value, input found_position,
                  input status, input entry_count, input is_empty, output ready);
endinterface

// ----- rtl/core/bounded_deque_with_search_core.sv -----
// Bounded deque with search: one request in, one response out per transfer.
// Push, clear and no-op go straight to the result state; a pop of a held entry waits for the registered
// memory read, search walks the entries up to the first match, and delete at p shifts every later entry down.
// Throughput: one request at a time; the single read port of the entry memory
// walks one entry per cycle in search and delete.
// Reset clears the pointers, count and handshake state; the entry memory is not cleared.
module bounded_deque_with_search_core (
    input  logic      clk,
    input  logic      rst_n,
    dqs_req_if.sink   req,
    dqs_rsp_if.source rsp
);
    import dqs_pkg::*;

    mem_req_t          mem_req;
    logic [DATA_W-1:0] mem_rdata;

    // controller
    dqs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    // entry ring storage
    dqs_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

endmodule

// ----- rtl/core/dqs_ram.sv -----
// simple dual-port entry memory, one write and one registered read per cycle
module dqs_ram #(
    parameter int DEPTH_P = 64,
    parameter int WIDTH_P = 32
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH_P)-1:0] waddr,
    input  logic [WIDTH_P-1:0]         wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH_P)-1:0] raddr,
    output logic [WIDTH_P-1:0]         rdata
);

    logic [WIDTH_P-1:0] mem [DEPTH_P];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/dqs_ctrl.sv -----
// deque controller: request decode, ring pointers, search and delete walks, result register
module dqs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    dqs_req_if.sink           req,
    dqs_rsp_if.source         rsp,
    output dqs_pkg::mem_req_t mem_req,
    input  logic [dqs_pkg::DATA_W-1:0] mem_rdata
);
    import dqs_pkg::*;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   front_reg, front_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               rd_vld_reg, rd_vld_next;
    logic               out_valid_reg, out_valid_next;

    logic [DATA_W-1:0]  value_reg, value_next;
    logic [DATA_W-1:0]  res_value_reg, res_value_next;
    logic [POS_W-1:0]   res_found_reg, res_found_next;
    status_t            res_status_reg, res_status_next;

    logic [DATA_W-1:0]  out_value_reg;
    logic [POS_W-1:0]   out_found_reg;
    status_t            out_status_reg;
    logic [ENTRY_W-1:0] out_count_reg;
    logic               out_empty_reg;

    logic               accept;
    kind_t              kind_in;
    logic               full;
    logic               empty;
    logic [CMP_W-1:0]   pos_c;
    logic [CMP_W-1:0]   cnt_c;
    logic               pos_bad;
    logic               pos_last;
    logic [IDX_W-1:0]   front_dec;
    logic [IDX_W-1:0]   front_inc;
    logic               rd_issue;
    logic               match;
    logic               search_last;
    logic               delete_last;
    logic               out_load;

    // request decode
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign kind_in   = kind_t'(req.kind);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign pos_c     = CMP_W'(req.position);
    assign cnt_c     = CMP_W'(count_reg);
    assign pos_bad   = (pos_c >= cnt_c);
    assign pos_last  = (pos_c == cnt_c - CMP_W'(1));

    // ring pointer steps
    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - IDX_W'(1);
    assign front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + IDX_W'(1);

    // walk control for search and delete
    assign rd_issue    = ((state_reg == S_SEARCH) || (state_reg == S_DELETE)) &&
                         (rd_idx_reg < count_reg);
    assign match       = rd_vld_reg && (mem_rdata == value_reg);
    assign search_last = (cmp_idx_reg == count_reg - CNT_W'(1));
    assign delete_last = (cmp_idx_reg == count_reg - CNT_W'(2));
    assign out_load    = (state_reg == S_RESULT) && (!out_valid_reg || rsp.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (kind_in)
                        KIND_POP_FRONT, KIND_POP_BACK:
                            state_next = empty ? S_RESULT : S_POP_WAIT;
                        KIND_SEARCH:
                            state_next = empty ? S_RESULT : S_SEARCH;
                        KIND_DELETE:
                            state_next = (pos_bad || pos_last) ? S_RESULT : S_DELETE;
                        default:
                            state_next = S_RESULT;
                    endcase
                end
            end
            S_POP_WAIT:
                state_next = S_RESULT;
            S_SEARCH:
            begin
                if (rd_vld_reg && (match || search_last))
                begin
                    state_next = S_RESULT;
                end
            end
            S_DELETE:
            begin
                if (rd_vld_reg && delete_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // pointers, walk counters and pending result
    always_comb
    begin
        front_next      = front_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        rd_vld_next     = 1'b0;
        value_next      = value_reg;
        res_value_next  = res_value_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    value_next      = req.value;
                    res_value_next  = '0;
                    res_found_next  = '0;
                    res_status_next = STAT_OK;
                    rd_idx_next     = '0;
                    cmp_idx_next    = '0;
                    case (kind_in)
                        KIND_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                front_next = front_dec;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        KIND_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        KIND_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                front_next = front_inc;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        KIND_POP_BACK:
                        begin
                            if (empty)
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        KIND_SEARCH:
                            res_status_next = STAT_NOT_FOUND;
                        KIND_DELETE:
                        begin
                            if (pos_bad)
                            begin
                                res_status_next = STAT_BAD_POS;
                            end
                            else if (pos_last)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                rd_idx_next  = CNT_W'(req.position) + CNT_W'(1);
                                cmp_idx_next = CNT_W'(req.position);
                            end
                        end
                        KIND_CLEAR:
                        begin
                            front_next = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_POP_WAIT:
                res_value_next = mem_rdata;
            S_SEARCH:
            begin
                rd_vld_next = rd_issue;
                if (rd_issue)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (match)
                begin
                    res_found_next  = POS_W'(cmp_idx_reg);
                    res_status_next = STAT_OK;
                end
                else if (rd_vld_reg)
                begin
                    cmp_idx_next = cmp_idx_reg + CNT_W'(1);
                end
            end
            S_DELETE:
            begin
                rd_vld_next = rd_issue;
                if (rd_issue)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    cmp_idx_next = cmp_idx_reg + CNT_W'(1);
                    if (delete_last)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // memory accesses and result register handoff
    always_comb
    begin
        mem_req        = '0;
        out_valid_next = out_valid_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (kind_in)
                        KIND_PUSH_FRONT:
                        begin
                            mem_req.we    = !full;
                            mem_req.waddr = front_dec;
                            mem_req.wdata = req.value;
                        end
                        KIND_PUSH_BACK:
                        begin
                            mem_req.we    = !full;
                            mem_req.waddr = slot_add(front_reg, count_reg);
                            mem_req.wdata = req.value;
                        end
                        KIND_POP_FRONT:
                        begin
                            mem_req.re    = !empty;
                            mem_req.raddr = front_reg;
                        end
                        KIND_POP_BACK:
                        begin
                            mem_req.re    = !empty;
                            mem_req.raddr = slot_add(front_reg, count_reg - CNT_W'(1));
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                mem_req.re    = rd_issue;
                mem_req.raddr = slot_add(front_reg, rd_idx_reg);
            end
            S_DELETE:
            begin
                // copy entry i+1 down to i, read runs one ahead of the write
                mem_req.re    = rd_issue;
                mem_req.raddr = slot_add(front_reg, rd_idx_reg);
                mem_req.we    = rd_vld_reg;
                mem_req.waddr = slot_add(front_reg, cmp_idx_reg);
                mem_req.wdata = mem_rdata;
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            cmp_idx_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_idx_reg   <= cmp_idx_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        value_reg      <= value_next;
        res_value_reg  <= res_value_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_value_reg  <= res_value_reg;
            out_found_reg  <= res_found_reg;
            out_status_reg <= res_status_reg;
            out_count_reg  <= ENTRY_W'(count_reg);
            out_empty_reg  <= (count_reg == '0);
        end
    end

    // response channel
    assign rsp.valid          = out_valid_reg;
    assign rsp.result_value   = out_value_reg;
    assign rsp.found_position = out_found_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.entry_count    = out_count_reg;
    assign rsp.is_empty       = out_empty_reg;

endmodule

// ----- rtl/core/dqs_chk.sv -----
// port-level checker for the deque core, bound to the top level
module dqs_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [dqs_pkg::DATA_W-1:0]    result_value,
    input logic [dqs_pkg::POS_W-1:0]     found_position,
    input logic [dqs_pkg::STAT_W-1:0]    status,
    input logic [dqs_pkg::ENTRY_W-1:0]   entry_count,
    input logic                          is_empty
);
    import dqs_pkg::*;

    // empty flag agrees with the count
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (is_empty == (entry_count == '0)))
        else $error("is_empty disagrees with entry_count");

    // a refused push only happens on a full queue
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == STAT_FULL)) |-> (entry_count == ENTRY_W'(DEPTH)))
        else $error("full status with a non-full count");

    // an empty pop returns zero and leaves an empty queue
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == STAT_EMPTY)) |-> ((result_value == '0) && is_empty))
        else $error("empty status with data or entries");

    // a failed search reports position zero
    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == STAT_NOT_FOUND)) |-> (found_position == '0))
        else $error("not-found status with a nonzero position");

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(result_value) &&
                                       $stable(status) && $stable(entry_count)))
        else $error("response changed while stalled");

endmodule

bind bounded_deque_with_search_core dqs_chk u_dqs_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .result_value   (rsp.result_value),
    .found_position (rsp.found_position),
    .status         (rsp.status),
    .entry_count    (rsp.entry_count),
    .is_empty       (rsp.is_empty)
);

// ----- bench/tb_bounded_deque_with_search_core.sv -----
// testbench for the bounded deque with search: directed and random requests checked against a shadow deque
module tb_bounded_deque_with_search_core;
    timeunit 1ns;
    timeprecision 1ps;

    import dqs_pkg::*;

    // kind code that the block treats as a no-op
    localparam logic [KIND_W-1:0] KIND_NOP = 3'd7;
    localparam int RANDOM_OPS = 1600;
    localparam int SHOWN_MISMATCHES = 10;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } deque_op_t;

    typedef struct {
        logic signed [DATA_W-1:0] result_value;
        logic [POS_W-1:0]         found_position;
        status_t                  status;
        logic [ENTRY_W-1:0]       entry_count;
        logic                     is_empty;
    } deque_reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dqs_req_if req_ch ();
    dqs_rsp_if rsp_ch ();

    bounded_deque_with_search_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow copy of the deque contents
    logic signed [DATA_W-1:0] shadow_ring [DEPTH];
    logic [IDX_W-1:0]         shadow_front = '0;
    int                       shadow_count = 0;

    deque_op_t    pending_ops [$];
    deque_reply_t awaited_replies [$];

    // fill level as the stimulus generator tracks it
    int gen_count = 0;

    bit req_taken = 1'b0;
    bit rsp_taken = 1'b0;
    bit req_quiet = 1'b0;
    bit rsp_quiet = 1'b0;
    int req_gap = 0;
    int rsp_stall = 0;

    int mismatches = 0;
    int ops_sent = 0;
    int replies_seen = 0;
    int peak_fill = 0;
    int status_hits [8];

    always #10 clk = ~clk;

    function automatic int ring_slot(int offset);
        return (int'(shadow_front) + offset) % DEPTH;
    endfunction

    // idle cycles before the next transfer, with occasional runs of none
    function automatic int draw_wait(inout bit quiet);
        if ($urandom_range(0, 39) == 0)
        begin
            quiet = !quiet;
        end
        return quiet ? 0 : $urandom_range(0, 7);
    endfunction

    // apply one request to the shadow deque and queue the reply it yields
    task automatic apply_deque_op(input deque_op_t op);
        deque_reply_t r;
        int i;
        r.result_value = '0;
        r.found_position = '0;
        r.status = STAT_OK;
        case (op.kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK:
            begin
                if (shadow_count >= DEPTH)
                begin
                    r.status = STAT_FULL;
                end
                else if (op.kind == KIND_PUSH_FRONT)
                begin
                    shadow_front = IDX_W'((int'(shadow_front) + DEPTH - 1) % DEPTH);
                    shadow_ring[shadow_front] = op.value;
                    shadow_count++;
                end
                else
                begin
                    shadow_ring[ring_slot(shadow_count)] = op.value;
                    shadow_count++;
                end
            end
            KIND_POP_FRONT:
            begin
                if (shadow_count == 0)
                begin
                    r.status = STAT_EMPTY;
                end
                else
                begin
                    r.result_value = shadow_ring[shadow_front];
                    shadow_front = IDX_W'((int'(shadow_front) + 1) % DEPTH);
                    shadow_count--;
                end
            end
            KIND_POP_BACK:
            begin
                if (shadow_count == 0)
                begin
                    r.status = STAT_EMPTY;
                end
                else
                begin
                    r.result_value = shadow_ring[ring_slot(shadow_count - 1)];
                    shadow_count--;
                end
            end
            KIND_SEARCH:
            begin
                r.status = STAT_NOT_FOUND;
                for (i = 0; i < shadow_count; i++)
                begin
                    if (shadow_ring[ring_slot(i)] == op.value)
                    begin
                        r.found_position = POS_W'(i);
                        r.status = STAT_OK;
                        break;
                    end
                end
            end
            KIND_DELETE:
            begin
                if (int'(op.position) >= shadow_count)
                begin
                    r.status = STAT_BAD_POS;
                end
                else
                begin
                    for (i = int'(op.position); i + 1 < shadow_count; i++)
                    begin
                        shadow_ring[ring_slot(i)] = shadow_ring[ring_slot(i + 1)];
                    end
                    shadow_count--;
                end
            end
            KIND_CLEAR:
            begin
                shadow_front = '0;
                shadow_count = 0;
            end
            default:
            begin
            end
        endcase
        r.entry_count = ENTRY_W'(shadow_count);
        r.is_empty = (shadow_count == 0);
        awaited_replies.push_back(r);
    endtask

    // queue a request and follow the fill level it leads to
    task automatic add_op(input logic [KIND_W-1:0] kind, input logic signed [DATA_W-1:0] value,
                          input int position);
        deque_op_t op;
        op.kind = kind;
        op.value = value;
        op.position = POS_W'(position);
        pending_ops.push_back(op);
        case (kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK:
            begin
                if (gen_count < DEPTH)
                begin
                    gen_count++;
                end
            end
            KIND_POP_FRONT, KIND_POP_BACK:
            begin
                if (gen_count > 0)
                begin
                    gen_count--;
                end
            end
            KIND_DELETE:
            begin
                if (position < gen_count)
                begin
                    gen_count--;
                end
            end
            KIND_CLEAR:
            begin
                gen_count = 0;
            end
            default:
            begin
            end
        endcase
    endtask

    // values drawn mostly from a small set so that searches hit and duplicates occur
    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 2) == 0)
        begin
            return $urandom;
        end
        case ($urandom_range(0, 7))
            0: return 32'sd0;
            1: return -32'sd1;
            2: return 32'sh8000_0000;
            3: return 32'sh7fff_ffff;
            4: return 32'sd1;
            5: return 32'sh5a5a_5a5a;
            6: return 32'sd100;
            default: return -32'sd100;
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] pick_push();
        return $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
    endfunction

    // position for a delete: mostly a held entry, first and last often
    function automatic int pick_position();
        if (gen_count == 0 || $urandom_range(0, 4) == 0)
        begin
            return $urandom_range(0, 63);
        end
        case ($urandom_range(0, 3))
            0: return 0;
            1: return gen_count - 1;
            default: return $urandom_range(0, gen_count - 1);
        endcase
    endfunction

    task automatic add_mixed_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 22)
            add_op(KIND_PUSH_FRONT, pick_value(), $urandom_range(0, 63));
        else if (r < 44)
            add_op(KIND_PUSH_BACK, pick_value(), $urandom_range(0, 63));
        else if (r < 55)
            add_op(KIND_POP_FRONT, pick_value(), $urandom_range(0, 63));
        else if (r < 66)
            add_op(KIND_POP_BACK, pick_value(), $urandom_range(0, 63));
        else if (r < 82)
            add_op(KIND_SEARCH, pick_value(), $urandom_range(0, 63));
        else if (r < 95)
            add_op(KIND_DELETE, pick_value(), pick_position());
        else if (r < 97)
            add_op(KIND_CLEAR, pick_value(), $urandom_range(0, 63));
        else
            add_op(KIND_NOP, $urandom, $urandom_range(0, 63));
    endtask

    // request driver: presents queued requests after a random gap
    always @(negedge clk)
    begin
        logic next_valid;
        deque_op_t op;
        if (rst_n)
        begin
            next_valid = req_ch.valid;
            if (req_ch.valid && req_taken)
            begin
                next_valid = 1'b0;
                req_gap = draw_wait(req_quiet);
            end
            if (!next_valid)
            begin
                if (req_gap > 0)
                begin
                    req_gap--;
                end
                else if (pending_ops.size() > 0)
                begin
                    op = pending_ops.pop_front();
                    req_ch.kind <= op.kind;
                    req_ch.value <= op.value;
                    req_ch.position <= op.position;
                    next_valid = 1'b1;
                end
            end
            req_ch.valid <= next_valid;
        end
    end

    // response ready: stalls a random number of cycles per transfer
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_taken)
            begin
                rsp_stall = draw_wait(rsp_quiet);
            end
            if (rsp_stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_stall--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
        begin
            $display("%0t mismatch: %s", $realtime, what);
        end
    endtask

    // monitor: predicts on each request transfer, checks each response transfer
    always @(posedge clk)
    begin
        deque_op_t op;
        deque_reply_t want;
        req_taken <= rst_n && req_ch.valid && req_ch.ready;
        rsp_taken <= rst_n && rsp_ch.valid && rsp_ch.ready;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            op.kind = req_ch.kind;
            op.value = req_ch.value;
            op.position = req_ch.position;
            apply_deque_op(op);
            ops_sent++;
            if (shadow_count > peak_fill)
            begin
                peak_fill = shadow_count;
            end
        end
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            replies_seen++;
            if (awaited_replies.size() == 0)
            begin
                note_mismatch("response with no request outstanding");
            end
            else
            begin
                want = awaited_replies.pop_front();
                status_hits[want.status]++;
                if (rsp_ch.result_value !== want.result_value
                    || rsp_ch.found_position !== want.found_position
                    || rsp_ch.status !== want.status
                    || rsp_ch.entry_count !== want.entry_count
                    || rsp_ch.is_empty !== want.is_empty)
                begin
                    note_mismatch($sformatf(
                        "value %0d/%0d pos %0d/%0d status %0d/%0d count %0d/%0d empty %0b/%0b",
                        want.result_value, rsp_ch.result_value,
                        want.found_position, rsp_ch.found_position,
                        want.status, rsp_ch.status,
                        want.entry_count, rsp_ch.entry_count,
                        want.is_empty, rsp_ch.is_empty));
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        int total_ops;
        req_ch.valid = 1'b0;
        req_ch.kind = '0;
        req_ch.value = '0;
        req_ch.position = '0;
        rsp_ch.ready = 1'b0;

        // empty deque corner cases
        add_op(KIND_POP_FRONT, 32'sd0, 0);
        add_op(KIND_POP_BACK, 32'sd0, 0);
        add_op(KIND_SEARCH, 32'sd0, 0);
        add_op(KIND_DELETE, 32'sd0, 0);
        add_op(KIND_DELETE, -32'sd1, 63);
        add_op(KIND_NOP, 32'sh8000_0000, 63);
        // extremes at both ends: 0, min, max, -1, 1
        add_op(KIND_PUSH_BACK, 32'sh7fff_ffff, 0);
        add_op(KIND_PUSH_FRONT, 32'sh8000_0000, 0);
        add_op(KIND_PUSH_BACK, -32'sd1, 0);
        add_op(KIND_PUSH_FRONT, 32'sd0, 0);
        add_op(KIND_PUSH_BACK, 32'sd1, 0);
        add_op(KIND_SEARCH, 32'sh8000_0000, 0);
        add_op(KIND_SEARCH, 32'sd1, 0);
        add_op(KIND_SEARCH, 32'sd12345, 0);
        // delete out of range, then first, last and middle entries
        add_op(KIND_DELETE, 32'sd0, 5);
        add_op(KIND_DELETE, 32'sd0, 0);
        add_op(KIND_DELETE, 32'sd0, 3);
        add_op(KIND_DELETE, 32'sd0, 1);
        add_op(KIND_POP_BACK, 32'sd0, 0);
        add_op(KIND_POP_FRONT, 32'sd0, 0);
        // duplicates: search returns the first match
        add_op(KIND_PUSH_BACK, 32'sd7, 0);
        add_op(KIND_PUSH_BACK, 32'sd7, 0);
        add_op(KIND_SEARCH, 32'sd7, 0);
        add_op(KIND_CLEAR, 32'sd0, 0);
        add_op(KIND_POP_FRONT, 32'sd0, 0);

        // random phases: fill past full, drain past empty, or mixed traffic
        total_ops = pending_ops.size() + RANDOM_OPS;
        while (pending_ops.size() < total_ops)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    while (gen_count < DEPTH)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            add_op(KIND_SEARCH, pick_value(), $urandom_range(0, 63));
                        else
                            add_op(pick_push(), pick_value(), $urandom_range(0, 63));
                    end
                    repeat ($urandom_range(1, 4))
                    begin
                        add_op(pick_push(), pick_value(), $urandom_range(0, 63));
                    end
                    add_op(KIND_SEARCH, pick_value(), $urandom_range(0, 63));
                end
                1:
                begin
                    while (gen_count > 0)
                    begin
                        case ($urandom_range(0, 9))
                            0, 1, 2: add_op(KIND_POP_FRONT, pick_value(), $urandom_range(0, 63));
                            3, 4, 5: add_op(KIND_POP_BACK, pick_value(), $urandom_range(0, 63));
                            6: add_op(KIND_SEARCH, pick_value(), $urandom_range(0, 63));
                            default: add_op(KIND_DELETE, pick_value(), pick_position());
                        endcase
                    end
                    repeat ($urandom_range(1, 3))
                    begin
                        add_mixed_op();
                    end
                end
                default:
                begin
                    repeat ($urandom_range(30, 60))
                    begin
                        add_mixed_op();
                    end
                end
            endcase
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() > 0 || req_ch.valid)
        begin
            @(posedge clk);
        end
        while (awaited_replies.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d requests and %0d responses, peak fill %0d of %0d",
                 ops_sent, replies_seen, peak_fill, DEPTH);
        $display("refused pushes %0d, empty pops %0d, missed searches %0d, bad deletes %0d",
                 status_hits[STAT_FULL], status_hits[STAT_EMPTY],
                 status_hits[STAT_NOT_FOUND], status_hits[STAT_BAD_POS]);
        if (mismatches == 0 && awaited_replies.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial
    begin
        #15_000_000;
        $display("timeout with %0d responses outstanding", awaited_replies.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
